FILE: rtl/lscn_pkg.sv
// ----------------------------------------------------------------------------
// lscn_pkg
// Shared types and constants for the lightmap style combine/normalize block.
// ----------------------------------------------------------------------------
package lscn_pkg;

    localparam int STYLE_SLOTS = 4;
    localparam int GAIN_REGS   = 4;

    localparam int SAMPLE_W = 8;
    localparam int GAIN_W   = 16;
    localparam int SUM_W    = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int QUOT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [SAMPLE_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [SAMPLE_W-1:0] GREY_FULL = 8'd128;
    localparam logic [SAMPLE_W-1:0] GREY_SURF = 8'd64;
    localparam logic [SAMPLE_W-1:0] GREY_NONE = 8'd0;
    localparam logic [SUM_W-1:0]    SUM_MAX   = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_3    = 3'd4;

    typedef enum logic [1:0] {
        FILL_COMBINE = 2'd0,
        FILL_FULL    = 2'd1,
        FILL_SURF    = 2'd2,
        FILL_NONE    = 2'd3
    } t_fill_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FIN,
        S_NMUL,
        S_DIV,
        S_DWAIT,
        S_OUT
    } t_state;

endpackage

FILE: rtl/lscn_mul.sv
// ----------------------------------------------------------------------------
// lscn_mul
// Shared 8 x 16 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lscn_mul (
    input  logic                              i_clk,
    input  logic [lscn_pkg::SAMPLE_W-1:0]     i_a,
    input  logic [lscn_pkg::GAIN_W-1:0]       i_b,
    output logic [lscn_pkg::PROD_W-1:0]       o_prod
);

    logic [lscn_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= lscn_pkg::PROD_W'(i_a) * lscn_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/lscn_div.sv
// ----------------------------------------------------------------------------
// lscn_div
// Restoring divider, one quotient bit per cycle, eight bit quotient.
// The caller guarantees the quotient fits in eight bits.
// ----------------------------------------------------------------------------
module lscn_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [lscn_pkg::PROD_W-1:0]       i_num,
    input  logic [lscn_pkg::SUM_W-1:0]        i_den,
    output logic                              o_done,
    output logic [lscn_pkg::QUOT_W-1:0]       o_quot
);

    localparam int DSH_W = lscn_pkg::SUM_W + lscn_pkg::QUOT_W - 1;

    logic                          r_busy;
    logic                          r_done;
    logic [2:0]                    r_cnt;
    logic [lscn_pkg::PROD_W-1:0]   r_rem;
    logic [DSH_W-1:0]              r_dsh;
    logic [lscn_pkg::QUOT_W-1:0]   r_q;
    logic                          w_ge;
    logic [lscn_pkg::PROD_W-1:0]   w_dsh_ext;

    assign w_dsh_ext = lscn_pkg::PROD_W'(r_dsh);
    assign w_ge      = (r_rem >= w_dsh_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath: divisor starts shifted up by seven and walks down one bit a step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= {i_den, 7'd0};
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - w_dsh_ext;
            end
            r_q   <= {r_q[lscn_pkg::QUOT_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/lightmap_style_combine_normalize.sv
// ----------------------------------------------------------------------------
// lightmap_style_combine_normalize
// Combines per-style lightmap samples into one texel and normalizes it.
// ----------------------------------------------------------------------------
// One beat is taken at a time; the input is not ready until that beat is done.
// A sample in combine mode is accepted and then takes a multiply and a
// saturating add per channel through one shared 8x16 multiplier; in a fill
// mode or for a slot without a gain it is only accepted. A last beat adds a
// finish and an output state, and when the brightest channel exceeds 255 also
// per channel one multiply by 255 on the same multiplier, then a divide in the bit-serial
// divider. The result sits in an output register, so a waiting result only
// stalls the block once the next texel's result is ready to be written.
// ----------------------------------------------------------------------------
module lightmap_style_combine_normalize (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [lscn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lscn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // sample stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [23:0]                         i_s_tdata,  // sample_red, sample_green, sample_blue
    input  logic [1:0]                          i_s_tuser,  // style_slot
    input  logic                                i_s_tlast,  // last_style
    // texel stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [23:0]                         o_m_tdata   // light_red, light_green, light_blue
);

    localparam int SW = lscn_pkg::SAMPLE_W;
    localparam int GW = lscn_pkg::GAIN_W;
    localparam int UW = lscn_pkg::SUM_W;

    lscn_pkg::t_state      r_state, n_state;
    lscn_pkg::t_fill_mode  r_fill;
    logic [1:0]            r_ch, n_ch;

    logic [SW-1:0]         r_samp [0:2];
    logic [1:0]            r_slot;
    logic                  r_last;
    logic [lscn_pkg::CFG_DATA_W-1:0] r_gain [0:lscn_pkg::GAIN_REGS-1];
    logic [UW-1:0]         r_sum  [0:2];
    logic [UW-1:0]         r_max;
    logic [SW-1:0]         r_res  [0:2];
    logic                  r_out_valid;
    logic [23:0]           r_out_data;

    // control strobes
    logic                  w_accept;
    logic                  w_acc_en;
    logic                  w_fin_en;
    logic                  w_div_start;
    logic                  w_out_load;
    logic                  w_use_gain;

    logic [SW-1:0]         w_mul_a;
    logic [GW-1:0]         w_mul_b;
    logic [lscn_pkg::PROD_W-1:0] w_prod;
    logic                  w_div_done;
    logic [lscn_pkg::QUOT_W-1:0] w_quot;

    logic [GW-1:0]         w_gain_ch;
    logic [UW:0]           w_add;
    logic [UW-1:0]         w_sat;
    logic [UW-1:0]         w_max_rg;
    logic [UW-1:0]         w_max;

    assign w_accept   = i_s_tvalid && (r_state == lscn_pkg::S_IDLE);
    assign o_s_tready = (r_state == lscn_pkg::S_IDLE);

    // a sample adds anything only in combine mode and for a slot that has a gain
    assign w_use_gain = (r_fill == lscn_pkg::FILL_COMBINE)
                     && (int'(i_s_tuser) < lscn_pkg::STYLE_SLOTS);

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= lscn_pkg::FILL_COMBINE;
            for (int i = 0; i < lscn_pkg::GAIN_REGS; i++) begin
                r_gain[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lscn_pkg::CFG_FILL_MODE: r_fill <= lscn_pkg::t_fill_mode'(i_cfg_data[1:0]);
                lscn_pkg::CFG_GAIN_0:    r_gain[0] <= i_cfg_data;
                lscn_pkg::CFG_GAIN_1:    r_gain[1] <= i_cfg_data;
                lscn_pkg::CFG_GAIN_2:    r_gain[2] <= i_cfg_data;
                lscn_pkg::CFG_GAIN_3:    r_gain[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- shared units
    always_comb begin
        case (r_ch)
            2'd0:    w_gain_ch = r_gain[r_slot][15:0];
            2'd1:    w_gain_ch = r_gain[r_slot][31:16];
            default: w_gain_ch = r_gain[r_slot][47:32];
        endcase
    end

    always_comb begin
        if (r_state == lscn_pkg::S_NMUL) begin
            w_mul_a = lscn_pkg::LEVEL_MAX;
            w_mul_b = r_sum[r_ch];
        end else begin
            w_mul_a = r_samp[r_ch];
            w_mul_b = w_gain_ch;
        end
    end

    lscn_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    lscn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_max),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // saturating accumulate of the integer part of the product
    assign w_add = {1'b0, r_sum[r_ch]} + {1'b0, w_prod[lscn_pkg::PROD_W-1:8]};
    assign w_sat = w_add[UW] ? lscn_pkg::SUM_MAX : w_add[UW-1:0];

    assign w_max_rg = (r_sum[0] > r_sum[1]) ? r_sum[0] : r_sum[1];
    assign w_max    = (r_sum[2] > w_max_rg) ? r_sum[2] : w_max_rg;

    // ------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lscn_pkg::S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        w_acc_en    = 1'b0;
        w_fin_en    = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            lscn_pkg::S_IDLE: begin
                n_ch = '0;
                if (i_s_tvalid) begin
                    if (w_use_gain) begin
                        n_state = lscn_pkg::S_MUL;
                    end else if (i_s_tlast) begin
                        n_state = lscn_pkg::S_FIN;
                    end
                end
            end
            lscn_pkg::S_MUL: begin
                n_state = lscn_pkg::S_ACC;
            end
            lscn_pkg::S_ACC: begin
                w_acc_en = 1'b1;
                if (r_ch == 2'd2) begin
                    n_ch    = '0;
                    n_state = r_last ? lscn_pkg::S_FIN : lscn_pkg::S_IDLE;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = lscn_pkg::S_MUL;
                end
            end
            lscn_pkg::S_FIN: begin
                w_fin_en = 1'b1;
                n_ch     = '0;
                if (r_fill == lscn_pkg::FILL_COMBINE && w_max > UW'(lscn_pkg::LEVEL_MAX)) begin
                    n_state = lscn_pkg::S_NMUL;
                end else begin
                    n_state = lscn_pkg::S_OUT;
                end
            end
            lscn_pkg::S_NMUL: begin
                n_state = lscn_pkg::S_DIV;
            end
            lscn_pkg::S_DIV: begin
                w_div_start = 1'b1;
                n_state     = lscn_pkg::S_DWAIT;
            end
            lscn_pkg::S_DWAIT: begin
                if (w_div_done) begin
                    if (r_ch == 2'd2) begin
                        n_ch    = '0;
                        n_state = lscn_pkg::S_OUT;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = lscn_pkg::S_NMUL;
                    end
                end
            end
            lscn_pkg::S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = lscn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lscn_pkg::S_IDLE;
            end
        endcase
    end

    // --------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_samp[0] <= i_s_tdata[7:0];
            r_samp[1] <= i_s_tdata[15:8];
            r_samp[2] <= i_s_tdata[23:16];
            r_slot    <= i_s_tuser;
            r_last    <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else if (w_out_load) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else if (w_acc_en) begin
            r_sum[r_ch] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_en) begin
            r_max <= w_max;
            case (r_fill)
                lscn_pkg::FILL_FULL: begin
                    for (int i = 0; i < 3; i++) r_res[i] <= lscn_pkg::GREY_FULL;
                end
                lscn_pkg::FILL_SURF: begin
                    for (int i = 0; i < 3; i++) r_res[i] <= lscn_pkg::GREY_SURF;
                end
                lscn_pkg::FILL_NONE: begin
                    for (int i = 0; i < 3; i++) r_res[i] <= lscn_pkg::GREY_NONE;
                end
                default: begin
                    // already in range, pass through; overwritten when normalized
                    for (int i = 0; i < 3; i++) r_res[i] <= r_sum[i][SW-1:0];
                end
            endcase
        end else if (r_state == lscn_pkg::S_DWAIT && w_div_done) begin
            r_res[r_ch] <= w_quot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {r_res[2], r_res[1], r_res[0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: tb/tb_lightmap_style_combine_normalize.sv
// ----------------------------------------------------------------------------
// tb_lightmap_style_combine_normalize
// Drives per-style lightmap sample beats into the block and checks every
// texel it returns against a cycle-free prediction of the combined,
// saturated and max-normalized light level. A directed part covers the
// sample and gain extremes, every fill mode and a fill mode change within a
// texel. Random texels follow under three idling regimes, with the gain and
// fill registers rewritten between groups while the block is idle.
// ----------------------------------------------------------------------------
module tb_lightmap_style_combine_normalize;

    import lscn_pkg::*;

    localparam int BUSY_CYCLES = 64;    // longest beat plus the output register
    localparam int STALL_LIMIT = 5000;  // cycles without any beat on either side

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_texel;

    // predicts each texel from the accepted sample beats
    class texel_light_tracker;
        t_fill_mode       fill;
        logic [47:0]      gain [GAIN_REGS];
        logic [SUM_W-1:0] acc_red;
        logic [SUM_W-1:0] acc_green;
        logic [SUM_W-1:0] acc_blue;
        t_texel           pending[$];
        int               mismatches;

        function new();
            fill = FILL_COMBINE;
            foreach (gain[i]) gain[i] = '0;
            acc_red    = '0;
            acc_green  = '0;
            acc_blue   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FILL_MODE) begin
                fill = t_fill_mode'(data[1:0]);
            end else if (idx >= CFG_GAIN_0 && idx <= CFG_GAIN_3) begin
                gain[idx - CFG_GAIN_0] = data;
            end
        endfunction

        function logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] sum, logic [7:0] smp,
                                           logic [GAIN_W-1:0] g);
            logic [PROD_W-1:0] prod;
            logic [SUM_W:0]    total;
            prod  = PROD_W'(smp) * PROD_W'(g);
            total = (SUM_W+1)'(sum) + (SUM_W+1)'(prod[PROD_W-1:8]);
            return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
        endfunction

        function logic [7:0] scale_to_max(int unsigned c, int unsigned mx);
            int unsigned q;
            q = (c * 32'd255) / mx;
            return q[7:0];
        endfunction

        function void take_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic [1:0] slot, bit last);
            t_texel      t;
            int unsigned mx;
            if (fill == FILL_COMBINE) begin
                acc_red   = sat_add(acc_red,   r, gain[slot][15:0]);
                acc_green = sat_add(acc_green, g, gain[slot][31:16]);
                acc_blue  = sat_add(acc_blue,  b, gain[slot][47:32]);
            end
            if (!last) return;
            case (fill)
                FILL_FULL: begin
                    t.red = GREY_FULL; t.green = GREY_FULL; t.blue = GREY_FULL;
                end
                FILL_SURF: begin
                    t.red = GREY_SURF; t.green = GREY_SURF; t.blue = GREY_SURF;
                end
                FILL_NONE: begin
                    t.red = GREY_NONE; t.green = GREY_NONE; t.blue = GREY_NONE;
                end
                default: begin
                    mx = 32'(acc_red);
                    if (acc_green > mx) mx = 32'(acc_green);
                    if (acc_blue > mx) mx = 32'(acc_blue);
                    if (mx > LEVEL_MAX) begin
                        t.red   = scale_to_max(32'(acc_red), mx);
                        t.green = scale_to_max(32'(acc_green), mx);
                        t.blue  = scale_to_max(32'(acc_blue), mx);
                    end else begin
                        t.red   = acc_red[7:0];
                        t.green = acc_green[7:0];
                        t.blue  = acc_blue[7:0];
                    end
                end
            endcase
            acc_red   = '0;
            acc_green = '0;
            acc_blue  = '0;
            pending.push_back(t);
        endfunction

        function void check_texel(t_texel got);
            t_texel want;
            if (pending.size() == 0) begin
                $display("%0t: texel %h arrived with none expected", $time, got);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red expected %0d got %0d", $time, want.red, got.red);
                mismatches++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green expected %0d got %0d", $time, want.green, got.green);
                mismatches++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue expected %0d got %0d", $time, want.blue, got.blue);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [23:0]           i_s_tdata;
    logic [1:0]            i_s_tuser;
    logic                  i_s_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [23:0]           o_m_tdata;

    texel_light_tracker tracker;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 beats_sent;
    int                 stall_cycles;

    lightmap_style_combine_normalize i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            tracker.check_texel(t_texel'(o_m_tdata));
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("tb_lightmap_style_combine_normalize: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0100;
            3, 4:    return 16'($urandom_range(0, 16'h01FF));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // fill mode with junk in the unused upper bits
    task automatic write_fill(input t_fill_mode mode);
        write_reg(CFG_FILL_MODE, {46'($urandom()) ^ {14'($urandom()), 32'd0}, mode});
    endtask

    task automatic send_sample(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [1:0] slot, input bit last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, g, r};
        i_s_tuser  <= slot;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tracker.take_sample(r, g, b, slot, last);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // hold the sender off until every predicted texel has come back
    task automatic drain_texels();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (tracker.pending.size() != 0) @(negedge i_clk);
    endtask

    // a non-last beat may still be in flight with nothing expected
    task automatic settle();
        drain_texels();
        repeat (BUSY_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure_random();
        int k;
        for (k = 0; k < GAIN_REGS; k++) begin
            write_reg(CFG_GAIN_0 + 3'(k), {pick_gain(), pick_gain(), pick_gain()});
        end
        if ($urandom_range(0, 5) == 0) begin
            write_reg(CFG_GAIN_3 + 3'($urandom_range(1, 3)),
                      {16'($urandom()), 32'($urandom())});
        end
        if ($urandom_range(0, 9) < 7) begin
            write_fill(FILL_COMBINE);
        end else begin
            write_fill(t_fill_mode'($urandom_range(1, 3)));
        end
    endtask

    task automatic run_phase(input int tx, input int rx, input int beats);
        int stop_at;
        int n;
        int k;
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            settle();
            configure_random();
            repeat ($urandom_range(4, 12)) begin
                n = $urandom_range(1, 5);
                for (k = 0; k < n; k++) begin
                    send_sample(pick_sample(), pick_sample(), pick_sample(),
                                2'($urandom_range(0, 3)), k == n - 1);
                end
                if ($urandom_range(0, 14) == 0) drain_texels();
            end
            // leave a texel open across the register change
            if ($urandom_range(0, 3) == 0) begin
                send_sample(pick_sample(), pick_sample(), pick_sample(),
                            2'($urandom_range(0, 3)), 1'b0);
            end
        end
    endtask

    initial begin
        tracker      = new();
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_s_tlast    = 1'b0;
        i_m_tready   = 1'b0;
        tx_idle_pct  = 9;
        rx_idle_pct  = 58;
        beats_sent   = 0;
        stall_cycles = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unity, maximum and zero gains, one random slot
        write_reg(CFG_GAIN_0, {16'h0100, 16'h0100, 16'h0100});
        write_reg(CFG_GAIN_1, {16'hFFFF, 16'hFFFF, 16'hFFFF});
        write_reg(CFG_GAIN_2, 48'd0);
        write_reg(CFG_GAIN_3, {pick_gain(), pick_gain(), pick_gain()});
        write_reg(CFG_GAIN_3 + 3'd1, 48'hFFFF_FFFF_FFFF);
        write_fill(FILL_COMBINE);

        send_sample(8'd0, 8'd0, 8'd0, 2'd0, 1'b1);
        send_sample(8'd255, 8'd255, 8'd255, 2'd0, 1'b1);
        // brightest channel over 255 forces the divide
        send_sample(8'd255, 8'd128, 8'd1, 2'd0, 1'b0);
        send_sample(8'd255, 8'd0, 8'd0, 2'd0, 1'b1);
        // saturation at 65535
        send_sample(8'd255, 8'd1, 8'd0, 2'd1, 1'b0);
        send_sample(8'd255, 8'd255, 8'd0, 2'd1, 1'b0);
        send_sample(8'd255, 8'd255, 8'd255, 2'd2, 1'b1);
        // every slot in one texel
        send_sample(8'd10, 8'd20, 8'd30, 2'd0, 1'b0);
        send_sample(8'd0, 8'd0, 8'd1, 2'd1, 1'b0);
        send_sample(8'd99, 8'd99, 8'd99, 2'd2, 1'b0);
        send_sample(pick_sample(), pick_sample(), pick_sample(), 2'd3, 1'b1);

        // fill mode switched while a texel is open
        send_sample(8'd100, 8'd50, 8'd25, 2'd0, 1'b0);
        settle();
        write_fill(FILL_FULL);
        send_sample(8'd7, 8'd7, 8'd7, 2'd0, 1'b1);
        send_sample(8'd1, 8'd2, 8'd3, 2'd0, 1'b0);
        settle();
        write_fill(FILL_SURF);
        send_sample(8'd4, 8'd5, 8'd6, 2'd1, 1'b0);
        send_sample(8'd4, 8'd5, 8'd6, 2'd1, 1'b1);
        send_sample(8'd1, 8'd2, 8'd3, 2'd0, 1'b0);
        settle();
        write_fill(FILL_COMBINE);
        send_sample(8'd10, 8'd20, 8'd30, 2'd0, 1'b1);
        send_sample(8'd200, 8'd0, 8'd0, 2'd0, 1'b0);
        settle();
        write_fill(FILL_NONE);
        send_sample(8'd200, 8'd200, 8'd200, 2'd0, 1'b1);
        settle();
        write_fill(FILL_COMBINE);
        send_sample(8'd5, 8'd6, 8'd7, 2'd0, 1'b1);

        run_phase(9, 58, 300);
        run_phase(58, 9, 300);
        run_phase(0, 0, 300);

        drain_texels();
        repeat (BUSY_CYCLES) @(posedge i_clk);
        if (tracker.pending.size() != 0) begin
            $display("%0t: %0d texels expected but never seen", $time, tracker.pending.size());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0) begin
            $display("tb_lightmap_style_combine_normalize: PASS");
        end else begin
            $display("tb_lightmap_style_combine_normalize: FAIL");
        end
        $finish;
    end

endmodule
